// File: rtl/box_filter_3x3_edge_normalized_unit_macros.svh
// assertion macros shared by the checker of the 3x3 box filter
`ifndef BOX_FILTER_3X3_EDGE_NORMALIZED_UNIT_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_NORMALIZED_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BF3EN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BF3EN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bf3en_pkg.sv
// shared types, constants and the divisor table of the 3x3 box filter
package bf3en_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int PIX_W       = 8;
    localparam int FW_W        = 11;
    localparam int FH_W        = 13;
    localparam int OX_W        = 10;
    localparam int OY_W        = 12;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    localparam logic [FW_W-1:0] FW_RESET = 11'd352;
    localparam logic [FH_W-1:0] FH_RESET = 13'd288;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_SUM   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic fetch;
        logic sum;
        logic div;
        logic next;
    } dp_cmd_t;

    typedef struct packed {
        logic has_result;
        logic more;
    } dp_status_t;

    // ceil(2^16 / n), exact for sums up to 9 * 255
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd6:    r = 17'd10923;
            4'd9:    r = 17'd7282;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bf3en_ram.sv
// generic single-write, single-read ram with registered read data
module bf3en_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bf3en_ctrl.sv
// controller state machine: sequences fetch, sum, divide and output per pixel
module bf3en_ctrl
    import bf3en_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = status.has_result ? ST_SUM : ST_IDLE;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    if (status.more)
                    begin
                        cmd.next   = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

endmodule

// File: rtl/bf3en_dp.sv
// datapath: config registers, line stores, window, neighbourhood sum and divide
module bf3en_dp
    import bf3en_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]      pixel,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic [PIX_W-1:0]      filtered,
    output logic [OX_W-1:0]       out_x,
    output logic [OY_W-1:0]       out_y,
    output logic                  last_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [CW-1:0]    col_max;
    logic [RW-1:0]    row_max;
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [PIX_W-1:0] pix_reg;
    logic [PIX_W-1:0] t1;
    logic [PIX_W-1:0] t2;
    logic [PIX_W-1:0] win_reg [0:5];
    logic [PIX_W-1:0] grid_reg [0:8];
    logic [CW-1:0]    c_item_reg;
    logic [RW-1:0]    r_item_reg;
    logic             hasx0_reg;
    logic             hasx1_reg;
    logic             hasy0_reg;
    logic             hasy1_reg;
    logic             xsel_reg;
    logic             ysel_reg;
    logic             x_is_c;
    logic             y_is_r;
    logic [2:0]       row_mask;
    logic [2:0]       col_mask;
    logic [1:0]       nrows;
    logic [1:0]       ncols;
    logic [SUM_W-1:0] sum_c;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0] prod;
    logic [CW-1:0]    x_val;
    logic [RW-1:0]    y_val;
    logic [PIX_W-1:0] filtered_reg;
    logic [OX_W-1:0]  out_x_reg;
    logic [OY_W-1:0]  out_y_reg;
    logic             last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FW_RESET;
            frame_height_reg <= FH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FH_W-1:0];
                default:          ;
            endcase
        end
    end

    // zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (frame_width_reg == '0)
            col_max = '0;
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            col_max = CW'(MAX_WIDTH - 1);
        else
            col_max = CW'(frame_width_reg - 1'b1);

        if (frame_height_reg == '0)
            row_max = '0;
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            row_max = RW'(MAX_HEIGHT - 1);
        else
            row_max = RW'(frame_height_reg - 1'b1);
    end

    // position of the next pixel; a config write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.fetch)
        begin
            if (col_reg == col_max)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == row_max) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pix_reg <= pixel;
        end
    end

    // read at the current column while idle, written back during fetch
    bf3en_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .clk   (clk),
        .we    (cmd.fetch),
        .waddr (col_reg),
        .wdata (pix_reg),
        .raddr (col_reg),
        .rdata (t1)
    );

    bf3en_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .clk   (clk),
        .we    (cmd.fetch),
        .waddr (col_reg),
        .wdata (t1),
        .raddr (col_reg),
        .rdata (t2)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (cmd.fetch)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= t2;
            win_reg[2] <= win_reg[3];
            win_reg[3] <= t1;
            win_reg[4] <= win_reg[5];
            win_reg[5] <= pix_reg;
        end
    end

    // 3x3 grid, rows r-2..r, columns c-2..c
    always_ff @(posedge clk)
    begin
        if (cmd.fetch)
        begin
            grid_reg[0] <= win_reg[0];
            grid_reg[1] <= win_reg[1];
            grid_reg[2] <= t2;
            grid_reg[3] <= win_reg[2];
            grid_reg[4] <= win_reg[3];
            grid_reg[5] <= t1;
            grid_reg[6] <= win_reg[4];
            grid_reg[7] <= win_reg[5];
            grid_reg[8] <= pix_reg;
            c_item_reg  <= col_reg;
            r_item_reg  <= row_reg;
        end
    end

    // which results this pixel completes, and which one is being worked on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hasx0_reg <= 1'b0;
            hasx1_reg <= 1'b0;
            hasy0_reg <= 1'b0;
            hasy1_reg <= 1'b0;
            xsel_reg  <= 1'b0;
            ysel_reg  <= 1'b0;
        end
        else if (cmd.fetch)
        begin
            hasx0_reg <= (col_reg != '0);
            hasx1_reg <= (col_reg == col_max);
            hasy0_reg <= (row_reg != '0);
            hasy1_reg <= (row_reg == row_max);
            xsel_reg  <= 1'b0;
            ysel_reg  <= 1'b0;
        end
        else if (cmd.next)
        begin
            if (!xsel_reg && hasx0_reg && hasx1_reg)
            begin
                xsel_reg <= 1'b1;
            end
            else
            begin
                xsel_reg <= 1'b0;
                ysel_reg <= 1'b1;
            end
        end
    end

    assign status.has_result = ((col_reg != '0) || (col_reg == col_max))
                            && ((row_reg != '0) || (row_reg == row_max));
    assign status.more = (!xsel_reg && hasx0_reg && hasx1_reg)
                      || (!ysel_reg && hasy0_reg && hasy1_reg);

    // target is the current column/row only on the right or bottom edge
    assign x_is_c = xsel_reg || !hasx0_reg;
    assign y_is_r = ysel_reg || !hasy0_reg;

    assign row_mask = y_is_r ? {1'b1, (r_item_reg != '0), 1'b0}
                             : {1'b1, 1'b1, (r_item_reg >= RW'(2))};
    assign col_mask = x_is_c ? {1'b1, (c_item_reg != '0), 1'b0}
                             : {1'b1, 1'b1, (c_item_reg >= CW'(2))};

    assign nrows = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
    assign ncols = 2'(col_mask[0]) + 2'(col_mask[1]) + 2'(col_mask[2]);

    always_comb
    begin
        sum_c = '0;
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (row_mask[j] && col_mask[i])
                begin
                    sum_c = sum_c + SUM_W'(grid_reg[j * 3 + i]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg <= sum_c;
            cnt_reg <= CNT_W'(ncols) * CNT_W'(nrows);
        end
    end

    // divide by the in-frame count through a reciprocal multiply
    assign prod  = PROD_W'(sum_reg) * PROD_W'(recip(cnt_reg));
    assign x_val = x_is_c ? c_item_reg : c_item_reg - 1'b1;
    assign y_val = y_is_r ? r_item_reg : r_item_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.div)
        begin
            filtered_reg <= prod[RECIP_SHIFT +: PIX_W];
            out_x_reg    <= OX_W'(x_val);
            out_y_reg    <= OY_W'(y_val);
            last_reg     <= x_is_c && y_is_r;
        end
    end

    assign filtered      = filtered_reg;
    assign out_x         = out_x_reg;
    assign out_y         = out_y_reg;
    assign last_of_frame = last_reg;

endmodule

// File: rtl/box_filter_3x3_edge_normalized_unit.sv
// one pixel in: the line stores are fetched and the window shifted, then each
// completed result passes through sum, divide and output, for n = 0..4 results
// per pixel, plus any output stall; one pixel in flight at a time.
// the first result is valid once its pixel beat has passed fetch, sum and divide.
// rst_n (async, active low) clears counters, window and control, and loads
// frame_width 352 and frame_height 288; line store contents stay undefined.
module box_filter_3x3_edge_normalized_unit
    import bf3en_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PIX_W-1:0]      filtered,
    output logic [OX_W-1:0]       out_x,
    output logic [OY_W-1:0]       out_y,
    output logic                  last_of_frame
);

    dp_cmd_t    cmd;
    dp_status_t status;

    bf3en_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    bf3en_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel         (pixel),
        .cmd           (cmd),
        .status        (status),
        .filtered      (filtered),
        .out_x         (out_x),
        .out_y         (out_y),
        .last_of_frame (last_of_frame)
    );

endmodule

// File: rtl/bf3en_checker.sv
// port-level checker for the 3x3 box filter, bound to the top level
`include "box_filter_3x3_edge_normalized_unit_macros.svh"

module bf3en_checker
    import bf3en_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] filtered,
    input logic [OX_W-1:0]  out_x,
    input logic [OY_W-1:0]  out_y
);

    // a stalled result beat holds
    `BF3EN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filtered) && $stable(out_x) && $stable(out_y), "stalled result beat changed")

    // no pixel is taken while a result waits
    `BF3EN_ASSERT_SAME(a_busy_while_out, out_valid, in_stall, "input open while result pending")

    // a taken pixel closes the input for at least the fetch cycle
    `BF3EN_ASSERT_NEXT(a_stall_after_accept, in_valid && !in_stall, in_stall && !out_valid, "input not closed after pixel beat")

    // each result needs a new sum and divide, so beats never come back to back
    `BF3EN_ASSERT_NEXT(a_out_gap, out_valid && !out_stall, !out_valid, "result beats back to back")

endmodule

bind box_filter_3x3_edge_normalized_unit bf3en_checker u_bf3en_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .out_x     (out_x),
    .out_y     (out_y)
);
